@@ hw/rtl/bdf_pkg.sv @@
// Shared types and constants for the button debounce forwarder.
package bdf_pkg;

    localparam int COUNT_W  = 6;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W = 3;

    // item function codes
    localparam logic [1:0] FUNC_POLL        = 2'd0;
    localparam logic [1:0] FUNC_POWER_SHORT = 2'd1;
    localparam logic [1:0] FUNC_POWER_LONG  = 2'd2;
    localparam logic [1:0] FUNC_RESET_PRESS = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_POLLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PRESS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_WIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOCK     = 3'd4;

    // reset values
    localparam logic [COUNT_W-1:0] STABLE_POLLS_RST = 6'd6;
    localparam logic [TICKS_W-1:0] SHORT_PRESS_RST  = 16'd60;
    localparam logic [TICKS_W-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [TICKS_W-1:0] ACTIVITY_WIN_RST = 16'd2000;
    localparam logic [TICKS_W-1:0] IDLE_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [1:0] func;
        logic       power_sense_level;
        logic       reset_sense_level;
        logic       disk_led_level;
    } in_item_t;

    typedef struct packed {
        logic power_pressed;
        logic reset_pressed;
        logic power_forward;
        logic reset_forward;
        logic disk_recent;
        logic trigger_taken;
    } out_item_t;

    // settings every lane sees
    typedef struct packed {
        logic [COUNT_W-1:0] stable_polls;
        logic               press_lock;
    } lane_cfg_t;

    // per-lane control for one transaction
    typedef struct packed {
        logic               poll;
        logic               load;
        logic [TICKS_W-1:0] load_ticks;
        logic               sense_level;
    } lane_ctrl_t;

    // post-update lane state
    typedef struct packed {
        logic pressed;
        logic forward;
    } lane_res_t;

endpackage

@@ hw/rtl/bdf_lane.sv @@
// One button channel: debounce, software press countdown and forwarding.
module bdf_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bdf_pkg::lane_cfg_t    cfg,
    input  bdf_pkg::lane_ctrl_t   ctrl,
    output bdf_pkg::lane_res_t    res
);

    logic                          last_raw_reg, last_raw_next;
    logic [bdf_pkg::COUNT_W-1:0]   stable_count_reg, stable_count_next;
    logic                          debounced_reg, debounced_next;
    logic [bdf_pkg::TICKS_W-1:0]   press_remaining_reg, press_remaining_next;
    logic                          forwarding_reg, forwarding_next;
    logic                          raw;
    logic [bdf_pkg::TICKS_W-1:0]   remaining_dec;

    assign raw = ~ctrl.sense_level;
    assign remaining_dec = (press_remaining_reg != '0) ?
                           press_remaining_reg - 1'b1 : press_remaining_reg;

    always_comb
    begin
        last_raw_next        = last_raw_reg;
        stable_count_next    = stable_count_reg;
        debounced_next       = debounced_reg;
        press_remaining_next = press_remaining_reg;
        forwarding_next      = forwarding_reg;
        if (ctrl.poll)
        begin
            if (raw == last_raw_reg)
            begin
                if (stable_count_reg < cfg.stable_polls)
                    stable_count_next = stable_count_reg + 1'b1;
            end
            else
            begin
                stable_count_next = '0;
                last_raw_next     = raw;
            end
            if (stable_count_next >= cfg.stable_polls)
                debounced_next = raw;
            press_remaining_next = remaining_dec;
            forwarding_next = (debounced_next | (remaining_dec != '0)) & ~cfg.press_lock;
        end
        else if (ctrl.load)
        begin
            press_remaining_next = ctrl.load_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg        <= 1'b0;
            stable_count_reg    <= '0;
            debounced_reg       <= 1'b0;
            press_remaining_reg <= '0;
            forwarding_reg      <= 1'b0;
        end
        else
        begin
            last_raw_reg        <= last_raw_next;
            stable_count_reg    <= stable_count_next;
            debounced_reg       <= debounced_next;
            press_remaining_reg <= press_remaining_next;
            forwarding_reg      <= forwarding_next;
        end
    end

    assign res.pressed = debounced_next;
    assign res.forward = forwarding_next;

    a_lock_blocks_forward: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.poll && cfg.press_lock |=> !forwarding_reg)
        else $error("lane forwards under press lock");

    a_bounce_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.poll && (raw != last_raw_reg) |=> stable_count_reg == '0)
        else $error("stable count not cleared on raw change");

    a_load_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.poll && ctrl.load |=> press_remaining_reg == $past(ctrl.load_ticks))
        else $error("press countdown not loaded");

endmodule

@@ hw/rtl/bdf_activity.sv @@
// Disk activity window: ticks since the disk LED was last active.
module bdf_activity (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        poll,
    input  logic                        disk_led_level,
    input  logic [bdf_pkg::TICKS_W-1:0] window_ticks,
    output logic                        recent
);

    logic [bdf_pkg::TICKS_W-1:0] idle_ticks_reg, idle_ticks_next;

    always_comb
    begin
        idle_ticks_next = idle_ticks_reg;
        if (poll)
        begin
            if (!disk_led_level)
                idle_ticks_next = '0;
            else if (idle_ticks_reg != bdf_pkg::IDLE_MAX)
                idle_ticks_next = idle_ticks_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_ticks_reg <= bdf_pkg::IDLE_MAX;
        else
            idle_ticks_reg <= idle_ticks_next;
    end

    assign recent = idle_ticks_next < window_ticks;

endmodule

@@ hw/rtl/button_debounce_forwarder.sv @@
// Top level: config registers, two button lanes, activity window, result buffer.
//
// Takes one item per clock while the skid register is empty and returns one
// result per item. The two button lanes and the disk activity counter update
// in the cycle an item is taken; the merged result is registered into the
// output register, or into the one-entry skid register behind it while the
// output is full; a full skid drops input ready. With out_ready held high the
// block sustains one transaction per clock. Configuration writes are always taken.
module button_debounce_forwarder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bdf_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bdf_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdf_pkg::TICKS_W-1:0]     cfg_data
);

    logic [bdf_pkg::COUNT_W-1:0] stable_polls_reg;
    logic [bdf_pkg::TICKS_W-1:0] short_press_reg;
    logic [bdf_pkg::TICKS_W-1:0] long_press_reg;
    logic [bdf_pkg::TICKS_W-1:0] activity_win_reg;
    logic                        press_lock_reg;

    logic                 accept, poll, taken;
    bdf_pkg::lane_cfg_t   lane_cfg;
    bdf_pkg::lane_ctrl_t  power_ctrl, reset_ctrl;
    bdf_pkg::lane_res_t   power_res, reset_res;
    logic                 disk_recent;
    bdf_pkg::out_item_t   result;

    logic                 out_valid_reg, out_valid_next;
    bdf_pkg::out_item_t   out_data_reg, out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    bdf_pkg::out_item_t   skid_data_reg, skid_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_polls_reg <= bdf_pkg::STABLE_POLLS_RST;
            short_press_reg  <= bdf_pkg::SHORT_PRESS_RST;
            long_press_reg   <= bdf_pkg::LONG_PRESS_RST;
            activity_win_reg <= bdf_pkg::ACTIVITY_WIN_RST;
            press_lock_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bdf_pkg::REG_STABLE_POLLS: stable_polls_reg <= cfg_data[bdf_pkg::COUNT_W-1:0];
                bdf_pkg::REG_SHORT_PRESS:  short_press_reg  <= cfg_data;
                bdf_pkg::REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                bdf_pkg::REG_ACTIVITY_WIN: activity_win_reg <= cfg_data;
                bdf_pkg::REG_PRESS_LOCK:   press_lock_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_ready = ~skid_valid_reg;
    assign accept   = in_valid & in_ready;
    assign poll     = accept & (in_data.func == bdf_pkg::FUNC_POLL);
    assign taken    = accept & (in_data.func != bdf_pkg::FUNC_POLL) & ~press_lock_reg;

    assign lane_cfg.stable_polls = stable_polls_reg;
    assign lane_cfg.press_lock   = press_lock_reg;

    assign power_ctrl.poll        = poll;
    assign power_ctrl.load        = taken & ((in_data.func == bdf_pkg::FUNC_POWER_SHORT) |
                                             (in_data.func == bdf_pkg::FUNC_POWER_LONG));
    assign power_ctrl.load_ticks  = (in_data.func == bdf_pkg::FUNC_POWER_LONG) ?
                                    long_press_reg : short_press_reg;
    assign power_ctrl.sense_level = in_data.power_sense_level;

    assign reset_ctrl.poll        = poll;
    assign reset_ctrl.load        = taken & (in_data.func == bdf_pkg::FUNC_RESET_PRESS);
    assign reset_ctrl.load_ticks  = short_press_reg;
    assign reset_ctrl.sense_level = in_data.reset_sense_level;

    bdf_lane u_power_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (lane_cfg),
        .ctrl  (power_ctrl),
        .res   (power_res)
    );

    bdf_lane u_reset_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (lane_cfg),
        .ctrl  (reset_ctrl),
        .res   (reset_res)
    );

    bdf_activity u_activity (
        .clk            (clk),
        .rst_n          (rst_n),
        .poll           (poll),
        .disk_led_level (in_data.disk_led_level),
        .window_ticks   (activity_win_reg),
        .recent         (disk_recent)
    );

    // merge lane findings into one result
    assign result.power_pressed = power_res.pressed;
    assign result.reset_pressed = reset_res.pressed;
    assign result.power_forward = power_res.forward;
    assign result.reset_forward = reset_res.forward;
    assign result.disk_recent   = disk_recent;
    assign result.trigger_taken = taken;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_ready)
        begin
            // skid drains first; it is empty whenever a new item is accepted
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output is empty");

    a_accept_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

endmodule

@@ verif/button_debounce_forwarder_tb.sv @@
// Self-checking testbench for the two-lane button debounce forwarder.
`timescale 1ns / 100ps

module button_debounce_forwarder_tb;

    import bdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int TAIL_CYCLES    = 20;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 90;
    localparam int MAX_REPORTS    = 10;

    // indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // one row of the directed sequence: a register write or an input item
    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [TICKS_W-1:0]   reg_val;
        in_item_t             item;
        logic                 typed;
        out_item_t            typed_val;
    } step_row_t;

    localparam int DIR_ROWS = 31;

    // item = {func, power sense, reset sense, disk led}
    // typed result = {pwr pressed, rst pressed, pwr fwd, rst fwd, disk recent, taken}
    localparam step_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        // straight out of reset
        '{1'b0, '0, '0, {FUNC_POLL,        3'b111}, 1'b1, 6'b000000},
        '{1'b0, '0, '0, {FUNC_POWER_SHORT, 3'b000}, 1'b1, 6'b000001},
        '{1'b0, '0, '0, {FUNC_POWER_LONG,  3'b000}, 1'b1, 6'b000001},
        '{1'b0, '0, '0, {FUNC_RESET_PRESS, 3'b111}, 1'b1, 6'b000001},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b000}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b001}, 1'b0, '0},
        // zero threshold: debounced tracks raw on every poll
        '{1'b1, REG_STABLE_POLLS, 16'h0000, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b011}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b100}, 1'b0, '0},
        // zero-length software press
        '{1'b1, REG_SHORT_PRESS, 16'h0000, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_RESET_PRESS, 3'b101}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b111}, 1'b0, '0},
        // zero activity window
        '{1'b1, REG_ACTIVITY_WIN, 16'h0000, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b110}, 1'b0, '0},
        // lock refuses presses and blocks forwarding
        '{1'b1, REG_PRESS_LOCK, 16'h0001, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POWER_LONG,  3'b010}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b000}, 1'b0, '0},
        // unlock: forwarding stays stale until the next poll
        '{1'b1, REG_PRESS_LOCK, 16'h0000, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POWER_SHORT, 3'b111}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_RESET_PRESS, 3'b000}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b000}, 1'b0, '0},
        // writes to unmapped indexes change nothing
        '{1'b1, REG_SPARE_A, 16'hFFFF, '0, 1'b0, '0},
        '{1'b1, REG_SPARE_B, 16'hFFFF, '0, 1'b0, '0},
        // every register except the press lock at its top
        '{1'b1, REG_STABLE_POLLS, 16'hFFFF, '0, 1'b0, '0},
        '{1'b1, REG_SHORT_PRESS,  16'hFFFF, '0, 1'b0, '0},
        '{1'b1, REG_LONG_PRESS,   16'hFFFF, '0, 1'b0, '0},
        '{1'b1, REG_ACTIVITY_WIN, 16'hFFFF, '0, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POWER_LONG,  3'b111}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_RESET_PRESS, 3'b111}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b111}, 1'b0, '0},
        '{1'b0, '0, '0, {FUNC_POLL,        3'b110}, 1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICKS_W-1:0]   cfg_data;

    // predictor copy of the registers and lane state
    logic [COUNT_W-1:0] cfg_stable;
    logic [TICKS_W-1:0] cfg_short;
    logic [TICKS_W-1:0] cfg_long;
    logic [TICKS_W-1:0] cfg_window;
    logic               cfg_lock;
    logic               lane_last [2];
    logic [COUNT_W-1:0] lane_run  [2];
    logic               lane_db   [2];
    logic [TICKS_W-1:0] lane_soft [2];
    logic               lane_fwd  [2];
    logic [TICKS_W-1:0] idle_span;

    out_item_t pending_status [$];

    int  items_sent;
    int  results_seen;
    int  reg_writes;
    int  presses_refused;
    int  status_mismatches;
    int  burst_left;
    int  stuck_cycles;
    logic in_live;

    button_debounce_forwarder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void poll_lane(input int ch, input logic level);
        logic raw;
        raw = ~level;
        if (raw == lane_last[ch])
        begin
            if (lane_run[ch] < cfg_stable)
                lane_run[ch]++;
        end
        else
        begin
            lane_run[ch]  = '0;
            lane_last[ch] = raw;
        end
        if (lane_run[ch] >= cfg_stable)
            lane_db[ch] = raw;
        if (lane_soft[ch] != '0)
            lane_soft[ch]--;
        lane_fwd[ch] = (lane_db[ch] || lane_soft[ch] != '0) && !cfg_lock;
    endfunction

    function automatic out_item_t next_button_status(input in_item_t it);
        out_item_t st;
        st = '0;
        if (it.func == FUNC_POLL)
        begin
            poll_lane(0, it.power_sense_level);
            poll_lane(1, it.reset_sense_level);
            if (!it.disk_led_level)
                idle_span = '0;
            else if (idle_span != IDLE_MAX)
                idle_span++;
        end
        else if (cfg_lock)
            presses_refused++;
        else
        begin
            case (it.func)
                FUNC_POWER_SHORT: lane_soft[0] = cfg_short;
                FUNC_POWER_LONG:  lane_soft[0] = cfg_long;
                default:          lane_soft[1] = cfg_short;  // reset press
            endcase
            st.trigger_taken = 1'b1;
        end
        st.power_pressed = lane_db[0];
        st.reset_pressed = lane_db[1];
        st.power_forward = lane_fwd[0];
        st.reset_forward = lane_fwd[1];
        st.disk_recent   = idle_span < cfg_window;
        return st;
    endfunction

    function automatic int pick_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [TICKS_W-1:0] pick_ticks();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 24));
    endfunction

    // drop valid and hold off until every expected result is back
    task automatic drain_results();
        if (in_live)
        begin
            in_valid <= 1'b0;
            in_live = 1'b0;
        end
        do
            @(posedge clk);
        while (pending_status.size() != 0);
    endtask

    task automatic send_item(input in_item_t it, input logic typed,
                             input out_item_t typed_val, input int gap);
        out_item_t want;
        if (gap > 0)
        begin
            if (in_live)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        in_live = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        want = next_button_status(it);
        pending_status.push_back(typed ? typed_val : want);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_STABLE_POLLS: cfg_stable = val[COUNT_W-1:0];
            REG_SHORT_PRESS:  cfg_short  = val;
            REG_LONG_PRESS:   cfg_long   = val;
            REG_ACTIVITY_WIN: cfg_window = val;
            REG_PRESS_LOCK:   cfg_lock   = val[0];
            default:          ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, with runs of always-ready
    initial
    begin : result_sink
        int   stall;
        int   mode_left;
        logic no_stall;
        out_ready = 1'b0;
        mode_left = 0;
        no_stall  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (mode_left == 0)
            begin
                no_stall  = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            stall = no_stall ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        logic      bad;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_status.size() == 0)
            begin
                status_mismatches++;
                if (status_mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result %b", $time, out_data);
            end
            else
            begin
                want = pending_status.pop_front();
                bad  = (out_data.power_pressed !== want.power_pressed) ||
                       (out_data.reset_pressed !== want.reset_pressed) ||
                       (out_data.power_forward !== want.power_forward) ||
                       (out_data.reset_forward !== want.reset_forward) ||
                       (out_data.disk_recent   !== want.disk_recent)   ||
                       (out_data.trigger_taken !== want.trigger_taken);
                if (bad)
                begin
                    status_mismatches++;
                    if (status_mismatches <= MAX_REPORTS)
                        $display({"[%0t] result %0d mismatch (pp rp pf rf dr tt):",
                                  " exp %b %b %b %b %b %b got %b %b %b %b %b %b"},
                                 $time, results_seen,
                                 want.power_pressed, want.reset_pressed,
                                 want.power_forward, want.reset_forward,
                                 want.disk_recent, want.trigger_taken,
                                 out_data.power_pressed, out_data.reset_pressed,
                                 out_data.power_forward, out_data.reset_forward,
                                 out_data.disk_recent, out_data.trigger_taken);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles, %0d results outstanding",
                     $time, stuck_cycles, pending_status.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        in_item_t          it;
        logic              lvl  [3];
        int                hold [3];
        int unsigned       r;
        logic [COUNT_W-1:0] stab;
        logic [TICKS_W-1:0] shrt;
        logic [TICKS_W-1:0] lng;
        logic [TICKS_W-1:0] win;
        logic              lock;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_live    = 1'b0;
        burst_left = 0;
        items_sent        = 0;
        reg_writes        = 0;
        presses_refused   = 0;
        cfg_stable = STABLE_POLLS_RST;
        cfg_short  = SHORT_PRESS_RST;
        cfg_long   = LONG_PRESS_RST;
        cfg_window = ACTIVITY_WIN_RST;
        cfg_lock   = 1'b0;
        for (int c = 0; c < 2; c++)
        begin
            lane_last[c] = 1'b0;
            lane_run[c]  = '0;
            lane_db[c]   = 1'b0;
            lane_soft[c] = '0;
            lane_fwd[c]  = 1'b0;
        end
        idle_span = IDLE_MAX;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++)
        begin
            if (DIRECTED_ROWS[row].is_cfg)
                write_reg(DIRECTED_ROWS[row].reg_idx, DIRECTED_ROWS[row].reg_val);
            else
                send_item(DIRECTED_ROWS[row].item, DIRECTED_ROWS[row].typed,
                          DIRECTED_ROWS[row].typed_val, pick_gap());
        end

        for (int c = 0; c < 3; c++)
        begin
            lvl[c]  = 1'b1;
            hold[c] = 0;
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    stab = '0; shrt = '0; lng = '0; win = 16'd1; lock = 1'b0;
                end
                1:
                begin
                    stab = '1; shrt = '1; lng = '1; win = '1; lock = 1'b0;
                end
                default:
                begin
                    stab = 6'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 8));
                    shrt = pick_ticks();
                    lng  = pick_ticks();
                    win  = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                           : $urandom_range(1, 30));
                    lock = (ph == 2) || ($urandom_range(0, 5) == 0);
                end
            endcase
            // upper data bits are don't-care for the narrow registers
            r = $urandom;
            write_reg(REG_STABLE_POLLS, {r[9:0], stab});
            write_reg(REG_SHORT_PRESS, shrt);
            write_reg(REG_LONG_PRESS, lng);
            write_reg(REG_ACTIVITY_WIN, win);
            r = $urandom;
            write_reg(REG_PRESS_LOCK, {r[14:0], lock});
            if ($urandom_range(0, 1) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(0, 4) == 0)
                begin
                    it.func = 2'($urandom_range(FUNC_POWER_SHORT, FUNC_RESET_PRESS));
                    it.power_sense_level = 1'($urandom);
                    it.reset_sense_level = 1'($urandom);
                    it.disk_led_level    = 1'($urandom);
                end
                else
                begin
                    // held levels, button runs sized to the threshold, plus rare bounce
                    for (int c = 0; c < 3; c++)
                    begin
                        if (hold[c] == 0)
                        begin
                            lvl[c]  = ~lvl[c];
                            hold[c] = (c == 2) ? $urandom_range(0, 40)
                                               : $urandom_range(0, 2 * cfg_stable + 6);
                        end
                        else
                            hold[c]--;
                    end
                    it.func              = FUNC_POLL;
                    it.power_sense_level = lvl[0] ^ ($urandom_range(0, 3 * cfg_stable + 11) == 0);
                    it.reset_sense_level = lvl[1] ^ ($urandom_range(0, 3 * cfg_stable + 11) == 0);
                    it.disk_led_level    = lvl[2] ^ ($urandom_range(0, 11) == 0);
                end
                send_item(it, 1'b0, '0, pick_gap());
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d items (%0d directed) and checked %0d results across %0d reg writes.",
                 items_sent, items_sent - RAND_PHASES * PHASE_ITEMS, results_seen, reg_writes);
        $display("Random part: %0d setting phases incl. min and max; %0d presses refused by lock.",
                 RAND_PHASES, presses_refused);
        if (status_mismatches == 0 && pending_status.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
